>>> hw/rtl/rlpg_pkg.sv
// Shared constants and a type for the raster line pixel generator
package rlpg_pkg;

    localparam int COORD_BITS_DEF = 10;
    localparam int PITCH_BITS_DEF = 11;
    localparam int ADDR_BITS      = 22;
    localparam int COLOR_BITS     = 16;
    localparam int PITCH_RESET    = 1024;

    typedef enum logic
    {
        CMD_START = 1'b0,
        CMD_STEP  = 1'b1
    } cmd_t;

endpackage

>>> hw/rtl/rlpg_line_if.sv
// Command channel carrying line start and step transfers
interface rlpg_line_if
    import rlpg_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
();
    logic                  valid;
    logic                  ready;
    logic                  cmd;
    logic [COORD_BITS-1:0] x_start;
    logic [COORD_BITS-1:0] y_start;
    logic [COORD_BITS-1:0] x_end;
    logic [COORD_BITS-1:0] y_end;
    logic [COLOR_BITS-1:0] pen_color;

    modport source
    (
        output valid, cmd, x_start, y_start, x_end, y_end, pen_color,
        input  ready
    );

    modport sink
    (
        input  valid, cmd, x_start, y_start, x_end, y_end, pen_color,
        output ready
    );
endinterface

>>> hw/rtl/rlpg_pix_if.sv
// Pixel write channel towards the frame buffer
interface rlpg_pix_if
    import rlpg_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [ADDR_BITS-1:0] pixel_address;
    logic [COLOR_BITS-1:0] pixel_value;
    logic                 last_pixel;

    modport source
    (
        output valid, pixel_address, pixel_value, last_pixel,
        input  ready
    );

    modport sink
    (
        input  valid, pixel_address, pixel_value, last_pixel,
        output ready
    );
endinterface

>>> hw/rtl/rlpg_setup.sv
// Line setup decode: start address, lengths and address steps from two endpoints
module rlpg_setup
    import rlpg_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int PITCH_BITS = PITCH_BITS_DEF
)
(
    input  logic [COORD_BITS-1:0] x_start,
    input  logic [COORD_BITS-1:0] y_start,
    input  logic [COORD_BITS-1:0] x_end,
    input  logic [COORD_BITS-1:0] y_end,
    input  logic [PITCH_BITS:0]   pitch,
    output logic [ADDR_BITS-1:0]  start_addr,
    output logic [COORD_BITS:0]   major_len,
    output logic [COORD_BITS:0]   minor_len,
    output logic [PITCH_BITS+1:0] major_delta,
    output logic [PITCH_BITS+2:0] diag_delta
);

    localparam int LEN_W  = COORD_BITS + 1;
    localparam int DW     = PITCH_BITS + 2;
    localparam int PROD_W = COORD_BITS + PITCH_BITS + 1;
    localparam int MW     = ((PROD_W > ADDR_BITS) ? PROD_W : ADDR_BITS) + 1;

    logic                  xneg;
    logic                  yneg;
    logic [COORD_BITS-1:0] adx;
    logic [COORD_BITS-1:0] ady;
    logic [COORD_BITS-1:0] x_sel;
    logic [COORD_BITS-1:0] y_sel;
    logic [LEN_W-1:0]      lx;
    logic [LEN_W-1:0]      ly;
    logic [DW-1:0]         pitch_d;
    logic [DW-1:0]         sx;
    logic [DW-1:0]         sy;
    logic [DW-1:0]         minor_delta;
    logic [MW-1:0]         lin;

    assign xneg    = x_end < x_start;
    assign yneg    = y_end < y_start;
    assign adx     = xneg ? (x_start - x_end) : (x_end - x_start);
    assign ady     = yneg ? (y_start - y_end) : (y_end - y_start);
    assign lx      = {1'b0, adx} + LEN_W'(1);
    assign ly      = {1'b0, ady} + LEN_W'(1);
    assign pitch_d = DW'(pitch);
    assign sx      = xneg ? '1 : DW'(1);
    assign sy      = yneg ? (DW'(0) - pitch_d) : pitch_d;

    // horizontal and vertical lines start from the smaller coordinate
    assign x_sel = (xneg && (ady == '0)) ? x_end : x_start;
    assign y_sel = (yneg && (adx == '0)) ? y_end : y_start;

    assign lin        = MW'(y_sel) * MW'(pitch) + MW'(x_sel);
    assign start_addr = lin[ADDR_BITS-1:0];

    always_comb
    begin
        major_len   = LEN_W'(1);
        minor_len   = '0;
        major_delta = '0;
        minor_delta = '0;
        priority if ((adx == '0) && (ady == '0))
        begin
            major_len = LEN_W'(1);
        end
        else if (adx == '0)
        begin
            major_len   = {1'b0, ady};
            major_delta = pitch_d;
        end
        else if (ady == '0)
        begin
            major_len   = {1'b0, adx};
            major_delta = DW'(1);
        end
        else if (lx < ly)
        begin
            major_len   = ly;
            minor_len   = lx;
            major_delta = sy;
            minor_delta = sx;
        end
        else
        begin
            major_len   = lx;
            minor_len   = ly;
            major_delta = sx;
            minor_delta = sy;
        end
    end

    assign diag_delta = {major_delta[DW-1], major_delta} + {minor_delta[DW-1], minor_delta};

endmodule

>>> hw/rtl/raster_line_pixel_generator.sv
// Top level of the raster line pixel generator
// Draws one line at a time into a linear frame buffer. A start transfer on the line
// channel yields the first pixel write, and each step transfer the next one, with
// last_pixel marking the final pixel; a step with no line in progress yields nothing
// and a start always drops any line in progress. One transfer is taken every cycle while
// the pixel channel does not hold back the output: the endpoint decode and the
// x + y * row_pitch multiply sit before the input register, and the error accumulator
// update and address step sit between it and the result register, so a pixel write is
// offered from the result register once its transfer has passed the input register.
// Write row_pitch only while no line work is outstanding.
module raster_line_pixel_generator
    import rlpg_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int PITCH_BITS = PITCH_BITS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                row_pitch_we,
    input  logic [PITCH_BITS:0] row_pitch,
    rlpg_line_if.sink           line,
    rlpg_pix_if.source          pixel
);

    localparam int LEN_W = COORD_BITS + 1;
    localparam int DW    = PITCH_BITS + 2;

    logic [PITCH_BITS:0]   pitch_reg;

    logic [ADDR_BITS-1:0]  dec_addr;
    logic [LEN_W-1:0]      dec_major;
    logic [LEN_W-1:0]      dec_minor;
    logic [DW-1:0]         dec_mdelta;
    logic [DW:0]           dec_ddelta;

    logic                  s1_valid_reg;
    logic                  s1_cmd_reg;
    logic [ADDR_BITS-1:0]  s1_addr_reg;
    logic [LEN_W-1:0]      s1_major_reg;
    logic [LEN_W-1:0]      s1_minor_reg;
    logic [DW-1:0]         s1_mdelta_reg;
    logic [DW:0]           s1_ddelta_reg;
    logic [COLOR_BITS-1:0] s1_color_reg;

    logic                  busy_reg;
    logic [ADDR_BITS-1:0]  cur_addr_reg;
    logic [LEN_W-1:0]      acc_reg;
    logic [LEN_W-1:0]      major_reg;
    logic [LEN_W-1:0]      minor_reg;
    logic [LEN_W-1:0]      left_reg;
    logic [DW-1:0]         mdelta_reg;
    logic [DW:0]           ddelta_reg;
    logic [COLOR_BITS-1:0] color_reg;

    logic                  out_valid_reg;
    logic [ADDR_BITS-1:0]  out_addr_reg;
    logic [COLOR_BITS-1:0] out_color_reg;
    logic                  out_last_reg;

    logic                  line_xfer;
    logic                  out_free;
    logic                  s1_fire;
    logic                  s1_start;
    logic                  emit;
    logic [ADDR_BITS-1:0]  e_addr;
    logic [LEN_W-1:0]      e_acc;
    logic [LEN_W-1:0]      e_major;
    logic [LEN_W-1:0]      e_minor;
    logic [LEN_W-1:0]      e_left;
    logic [DW-1:0]         e_mdelta;
    logic [DW:0]           e_ddelta;
    logic [COLOR_BITS-1:0] e_color;
    logic [LEN_W:0]        acc_sum;
    logic                  take_minor;
    logic [DW:0]           step_d;
    logic [ADDR_BITS-1:0]  addr_next;
    logic [LEN_W-1:0]      acc_next;
    logic [LEN_W-1:0]      left_next;
    logic                  busy_next;

    rlpg_setup #(
        .COORD_BITS (COORD_BITS),
        .PITCH_BITS (PITCH_BITS)
    ) u_setup (
        .x_start     (line.x_start),
        .y_start     (line.y_start),
        .x_end       (line.x_end),
        .y_end       (line.y_end),
        .pitch       (pitch_reg),
        .start_addr  (dec_addr),
        .major_len   (dec_major),
        .minor_len   (dec_minor),
        .major_delta (dec_mdelta),
        .diag_delta  (dec_ddelta)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pitch_reg <= (PITCH_BITS + 1)'(PITCH_RESET);
        end
        else if (row_pitch_we)
        begin
            pitch_reg <= row_pitch;
        end
    end

    assign out_free   = !out_valid_reg || pixel.ready;
    assign s1_fire    = s1_valid_reg && out_free;
    assign line.ready = !s1_valid_reg || out_free;
    assign line_xfer  = line.valid && line.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (line.ready)
        begin
            s1_valid_reg <= line.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (line_xfer)
        begin
            s1_cmd_reg    <= line.cmd;
            s1_addr_reg   <= dec_addr;
            s1_major_reg  <= dec_major;
            s1_minor_reg  <= dec_minor;
            s1_mdelta_reg <= dec_mdelta;
            s1_ddelta_reg <= dec_ddelta;
            s1_color_reg  <= line.pen_color;
        end
    end

    // a start takes its fresh setup in place of the running line state
    assign s1_start = s1_cmd_reg == CMD_START;
    assign emit     = s1_start || busy_reg;
    assign e_addr   = s1_start ? s1_addr_reg   : cur_addr_reg;
    assign e_acc    = s1_start ? '0            : acc_reg;
    assign e_major  = s1_start ? s1_major_reg  : major_reg;
    assign e_minor  = s1_start ? s1_minor_reg  : minor_reg;
    assign e_left   = s1_start ? s1_major_reg  : left_reg;
    assign e_mdelta = s1_start ? s1_mdelta_reg : mdelta_reg;
    assign e_ddelta = s1_start ? s1_ddelta_reg : ddelta_reg;
    assign e_color  = s1_start ? s1_color_reg  : color_reg;

    assign acc_sum    = {1'b0, e_acc} + {1'b0, e_minor};
    assign take_minor = acc_sum >= {1'b0, e_major};
    assign acc_next   = take_minor ? LEN_W'(acc_sum - {1'b0, e_major}) : acc_sum[LEN_W-1:0];
    assign step_d     = take_minor ? e_ddelta : {e_mdelta[DW-1], e_mdelta};
    assign addr_next  = e_addr + {{(ADDR_BITS - DW - 1){step_d[DW]}}, step_d};
    assign left_next  = (e_left != '0) ? (e_left - LEN_W'(1)) : '0;
    assign busy_next  = left_next != '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg     <= 1'b0;
            cur_addr_reg <= '0;
            acc_reg      <= '0;
            major_reg    <= '0;
            minor_reg    <= '0;
            left_reg     <= '0;
            mdelta_reg   <= '0;
            ddelta_reg   <= '0;
            color_reg    <= '0;
        end
        else if (s1_fire && emit)
        begin
            busy_reg     <= busy_next;
            cur_addr_reg <= addr_next;
            acc_reg      <= acc_next;
            major_reg    <= e_major;
            minor_reg    <= e_minor;
            left_reg     <= left_next;
            mdelta_reg   <= e_mdelta;
            ddelta_reg   <= e_ddelta;
            color_reg    <= e_color;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_fire && emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (pixel.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire && emit)
        begin
            out_addr_reg  <= e_addr;
            out_color_reg <= e_color;
            out_last_reg  <= e_left <= LEN_W'(1);
        end
    end

    assign pixel.valid         = out_valid_reg;
    assign pixel.pixel_address = out_addr_reg;
    assign pixel.pixel_value   = out_color_reg;
    assign pixel.last_pixel    = out_last_reg;

    a_busy_has_pixels: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (left_reg != '0))
        else $error("line busy with no pixels left");

    a_acc_below_major: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (acc_reg < major_reg))
        else $error("error accumulator not below major length");

    a_final_step_idles: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && !s1_start && busy_reg && (left_reg == LEN_W'(1))) |=> !busy_reg)
        else $error("line still busy after its final pixel");

    a_idle_step_no_change: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && !emit) |=> ($stable(cur_addr_reg) && !busy_reg))
        else $error("step while idle altered line state");

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !line.ready |-> (s1_valid_reg && out_valid_reg && !pixel.ready))
        else $error("input stalled without a full pipeline");

endmodule
